@@ sv/dual_sensor_window_health_check_unit_assert.svh @@
// ---------------------------------------------------------------------------
// dual sensor window health check assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef DUAL_SENSOR_WINDOW_HEALTH_CHECK_UNIT_ASSERT_SVH
`define DUAL_SENSOR_WINDOW_HEALTH_CHECK_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define DSWHC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dswhc assertion failed");

// consequent holds in the cycle after the antecedent
`define DSWHC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dswhc assertion failed");

`endif

@@ sv/dswhc_pkg.sv @@
// ---------------------------------------------------------------------------
// dswhc_pkg
// shared types and constants of the dual sensor window health check
// ---------------------------------------------------------------------------
package dswhc_pkg;

  // sample width; the limit and bound registers share it
  localparam int SAMPLE_BITS = 13;

  // configuration register width and index width
  localparam int CFG_W     = SAMPLE_BITS;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_MODE    = 3'd0,
    REG_NOISE_LIMIT   = 3'd1,
    REG_CAL_MAIN_LOW  = 3'd2,
    REG_CAL_MAIN_HIGH = 3'd3,
    REG_CAL_AUX_LOW   = 3'd4,
    REG_CAL_AUX_HIGH  = 3'd5,
    REG_ZERO_LOW      = 3'd6,
    REG_ZERO_HIGH     = 3'd7
  } cfg_idx_t;

  // check mode codes
  localparam logic MODE_ZERO = 1'b0;
  localparam logic MODE_CAL  = 1'b1;

  // register reset values
  localparam logic                    RST_CHECK_MODE    = MODE_ZERO;
  localparam logic        [CFG_W-1:0] RST_NOISE_LIMIT   = 13'd16;
  localparam logic signed [CFG_W-1:0] RST_CAL_MAIN_LOW  = 13'sd40;
  localparam logic signed [CFG_W-1:0] RST_CAL_MAIN_HIGH = 13'sd350;
  localparam logic signed [CFG_W-1:0] RST_CAL_AUX_LOW   = 13'sd600;
  localparam logic signed [CFG_W-1:0] RST_CAL_AUX_HIGH  = 13'sd1030;
  localparam logic signed [CFG_W-1:0] RST_ZERO_LOW      = -13'sd10;
  localparam logic signed [CFG_W-1:0] RST_ZERO_HIGH     = 13'sd10;

  // configuration register file contents
  typedef struct packed {
    logic                    check_mode;
    logic        [CFG_W-1:0] noise_limit;
    logic signed [CFG_W-1:0] cal_main_low;
    logic signed [CFG_W-1:0] cal_main_high;
    logic signed [CFG_W-1:0] cal_aux_low;
    logic signed [CFG_W-1:0] cal_aux_high;
    logic signed [CFG_W-1:0] zero_low;
    logic signed [CFG_W-1:0] zero_high;
  } cfg_t;

  // per-transaction lane control
  typedef struct packed {
    logic take;
    logic last;
  } lane_ctrl_t;

  // verdict flags of one window
  typedef struct packed {
    logic pass;
    logic capture_error;
    logic noise_fail;
    logic range_fail;
  } verdict_t;

endpackage

@@ sv/dswhc_ifs.sv @@
// ---------------------------------------------------------------------------
// dswhc channel interfaces
// valid/ready channels for sample pairs and window verdicts
// ---------------------------------------------------------------------------
interface dswhc_in_if #(
  parameter int SAMPLE_BITS = 13
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] main_sample;
  logic                          main_valid;
  logic signed [SAMPLE_BITS-1:0] aux_sample;
  logic                          aux_valid;
  logic                          window_end;

  modport source (
    output valid, main_sample, main_valid, aux_sample, aux_valid, window_end,
    input  ready
  );
  modport sink (
    input  valid, main_sample, main_valid, aux_sample, aux_valid, window_end,
    output ready
  );
endinterface

interface dswhc_out_if #(
  parameter int SAMPLE_BITS = 13
);
  logic                          valid;
  logic                          ready;
  logic                          pass;
  logic                          capture_error;
  logic                          noise_fail;
  logic                          range_fail;
  logic signed [SAMPLE_BITS-1:0] main_mean;
  logic signed [SAMPLE_BITS-1:0] aux_mean;

  modport source (
    output valid, pass, capture_error, noise_fail, range_fail, main_mean, aux_mean,
    input  ready
  );
  modport sink (
    input  valid, pass, capture_error, noise_fail, range_fail, main_mean, aux_mean,
    output ready
  );
endinterface

@@ sv/dswhc_lane.sv @@
// ---------------------------------------------------------------------------
// dswhc_lane
// one sensor lane: running min, max, scaled exponential mean and error flag,
// with a snapshot taken on the last sample of a window
// ---------------------------------------------------------------------------
module dswhc_lane
  import dswhc_pkg::*;
#(
  parameter int SAMPLE_BITS = 13,
  parameter int MEAN_SHIFT  = 5,
  parameter int ACC_W       = SAMPLE_BITS + MEAN_SHIFT + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lane_ctrl_t                    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          smp_valid,
  output logic signed [SAMPLE_BITS-1:0] snap_max_r,
  output logic signed [SAMPLE_BITS:0]   snap_min_r,
  output logic signed [ACC_W-1:0]       snap_acc_r,
  output logic                          snap_err_r
);

  localparam int TW = ACC_W + MEAN_SHIFT + 1;
  localparam logic signed [SAMPLE_BITS:0] MIN_START = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt, max_upd;
  logic signed [SAMPLE_BITS:0]   min_r, min_nxt, min_upd;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt, acc_upd;
  logic                          err_r, err_nxt, err_upd;

  logic signed [SAMPLE_BITS:0] x_min;
  logic signed [TW-1:0]        acc_e;
  logic signed [TW-1:0]        x_e;
  logic signed [TW-1:0]        mix;

  // 31*acc + 32*x, floor divided by 32
  assign x_min = {sample[SAMPLE_BITS-1], sample};
  assign acc_e = {{(TW-ACC_W){acc_r[ACC_W-1]}}, acc_r};
  assign x_e   = {{(TW-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
  assign mix   = (acc_e <<< MEAN_SHIFT) - acc_e + (x_e <<< MEAN_SHIFT);

  // statistics after this sample
  always_comb begin
    max_upd = max_r;
    min_upd = min_r;
    acc_upd = acc_r;
    err_upd = err_r;
    if (smp_valid) begin
      if (sample > max_r) max_upd = sample;
      if (x_min < min_r) min_upd = x_min;
      acc_upd = mix[ACC_W+MEAN_SHIFT-1:MEAN_SHIFT];
    end else begin
      err_upd = 1'b1;
    end
  end

  // window state, cleared after the last sample
  always_comb begin
    max_nxt = max_r;
    min_nxt = min_r;
    acc_nxt = acc_r;
    err_nxt = err_r;
    if (ctrl.take) begin
      if (ctrl.last) begin
        max_nxt = '0;
        min_nxt = MIN_START;
        acc_nxt = '0;
        err_nxt = 1'b0;
      end else begin
        max_nxt = max_upd;
        min_nxt = min_upd;
        acc_nxt = acc_upd;
        err_nxt = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      min_r <= MIN_START;
      acc_r <= '0;
      err_r <= 1'b0;
    end else begin
      max_r <= max_nxt;
      min_r <= min_nxt;
      acc_r <= acc_nxt;
      err_r <= err_nxt;
    end
  end

  // snapshot of the finished window
  always_ff @(posedge clk) begin
    if (ctrl.take && ctrl.last) begin
      snap_max_r <= max_upd;
      snap_min_r <= min_upd;
      snap_acc_r <= acc_upd;
      snap_err_r <= err_upd;
    end
  end

endmodule

@@ sv/dswhc_merge.sv @@
// ---------------------------------------------------------------------------
// dswhc_merge
// combines both lane snapshots into means and the window verdict
// ---------------------------------------------------------------------------
module dswhc_merge
  import dswhc_pkg::*;
#(
  parameter int SAMPLE_BITS = 13,
  parameter int MEAN_SHIFT  = 5,
  parameter int ACC_W       = SAMPLE_BITS + MEAN_SHIFT + 1
) (
  input  logic                          clk,
  input  logic                          load,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] main_max,
  input  logic signed [SAMPLE_BITS:0]   main_min,
  input  logic signed [ACC_W-1:0]       main_acc,
  input  logic                          main_err,
  input  logic signed [SAMPLE_BITS-1:0] aux_max,
  input  logic signed [SAMPLE_BITS:0]   aux_min,
  input  logic signed [ACC_W-1:0]       aux_acc,
  input  logic                          aux_err,
  output verdict_t                      verdict_r,
  output logic signed [SAMPLE_BITS-1:0] main_mean_r,
  output logic signed [SAMPLE_BITS-1:0] aux_mean_r
);

  localparam int SPAN_W = SAMPLE_BITS + 2;
  localparam int NW     = (SPAN_W > CFG_W + 1) ? SPAN_W : CFG_W + 1;
  localparam int BW     = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS + 1 : CFG_W + 1;

  logic signed [SAMPLE_BITS-1:0] main_mean, aux_mean;
  logic signed [NW-1:0]          main_span, aux_span, limit_e;
  logic signed [BW-1:0]          mm_e, am_e;
  logic signed [BW-1:0]          main_lo, main_hi, aux_lo, aux_hi;
  logic                          err, noise, range_bad;
  verdict_t                      verdict;

  // floor of acc / 32 is a plain slice
  assign main_mean = main_acc[MEAN_SHIFT+SAMPLE_BITS-1:MEAN_SHIFT];
  assign aux_mean  = aux_acc[MEAN_SHIFT+SAMPLE_BITS-1:MEAN_SHIFT];

  // span check against the noise limit
  assign main_span = {{(NW-SAMPLE_BITS){main_max[SAMPLE_BITS-1]}}, main_max}
                   - {{(NW-SAMPLE_BITS-1){main_min[SAMPLE_BITS]}}, main_min};
  assign aux_span  = {{(NW-SAMPLE_BITS){aux_max[SAMPLE_BITS-1]}}, aux_max}
                   - {{(NW-SAMPLE_BITS-1){aux_min[SAMPLE_BITS]}}, aux_min};
  assign limit_e   = {{(NW-CFG_W){1'b0}}, cfg.noise_limit};
  assign noise     = (main_span > limit_e) || (aux_span > limit_e);

  // bounds of the current mode
  always_comb begin
    if (cfg.check_mode == MODE_CAL) begin
      main_lo = {{(BW-CFG_W){cfg.cal_main_low[CFG_W-1]}},  cfg.cal_main_low};
      main_hi = {{(BW-CFG_W){cfg.cal_main_high[CFG_W-1]}}, cfg.cal_main_high};
      aux_lo  = {{(BW-CFG_W){cfg.cal_aux_low[CFG_W-1]}},   cfg.cal_aux_low};
      aux_hi  = {{(BW-CFG_W){cfg.cal_aux_high[CFG_W-1]}},  cfg.cal_aux_high};
    end else begin
      main_lo = {{(BW-CFG_W){cfg.zero_low[CFG_W-1]}},  cfg.zero_low};
      main_hi = {{(BW-CFG_W){cfg.zero_high[CFG_W-1]}}, cfg.zero_high};
      aux_lo  = main_lo;
      aux_hi  = main_hi;
    end
  end

  assign mm_e      = {{(BW-SAMPLE_BITS){main_mean[SAMPLE_BITS-1]}}, main_mean};
  assign am_e      = {{(BW-SAMPLE_BITS){aux_mean[SAMPLE_BITS-1]}}, aux_mean};
  assign range_bad = (mm_e < main_lo) || (mm_e > main_hi) ||
                     (am_e < aux_lo) || (am_e > aux_hi);
  assign err       = main_err || aux_err;

  always_comb begin
    verdict.pass          = !err && !noise && !range_bad;
    verdict.capture_error = err;
    verdict.noise_fail    = noise;
    verdict.range_fail    = range_bad;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r   <= verdict;
      main_mean_r <= main_mean;
      aux_mean_r  <= aux_mean;
    end
  end

endmodule

@@ sv/dual_sensor_window_health_check_unit.sv @@
// ---------------------------------------------------------------------------
// dual_sensor_window_health_check_unit
// window health check of two pressure sensors: per-sensor lanes track
// min, max and mean, a merge stage issues one verdict per window
//
// channel   direction  content
// in_ch     sink       main/aux sample and capture flag, window_end
// out_ch    source     pass, error flags, main and aux mean
// cfg_*     write      index and data of one mode/limit/bound register
//
// one sample pair accepted every cycle while in_ch.ready is high; the lane
// update of min, max and mean is a registered step, so throughput is one
// transaction per clock unless in_ch stalls; after the window_end transaction
// a verdict passes the lane snapshot, then merge and output register
// rst_n is synchronous; it restores register defaults and empties the window
// a stalled out_ch holds one verdict plus one snapshot before in_ch stalls
// ---------------------------------------------------------------------------
module dual_sensor_window_health_check_unit
  import dswhc_pkg::*;
#(
  parameter int MEAN_SHIFT  = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dswhc_in_if.sink             in_ch,
  dswhc_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int ACC_W = SAMPLE_BITS + MEAN_SHIFT + 1;

  `include "dual_sensor_window_health_check_unit_assert.svh"

  cfg_t       cfg_r, cfg_nxt;
  lane_ctrl_t lane_ctrl;
  logic       s1_valid_r, s1_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_adv, s1_adv, in_acc, snap_load;

  logic signed [SAMPLE_BITS-1:0] main_max, aux_max;
  logic signed [SAMPLE_BITS:0]   main_min, aux_min;
  logic signed [ACC_W-1:0]       main_acc, aux_acc;
  logic                          main_err, aux_err;
  verdict_t                      verdict;
  logic signed [SAMPLE_BITS-1:0] main_mean, aux_mean;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_CHECK_MODE:    cfg_nxt.check_mode    = cfg_wdata[0];
        REG_NOISE_LIMIT:   cfg_nxt.noise_limit   = cfg_wdata;
        REG_CAL_MAIN_LOW:  cfg_nxt.cal_main_low  = cfg_wdata;
        REG_CAL_MAIN_HIGH: cfg_nxt.cal_main_high = cfg_wdata;
        REG_CAL_AUX_LOW:   cfg_nxt.cal_aux_low   = cfg_wdata;
        REG_CAL_AUX_HIGH:  cfg_nxt.cal_aux_high  = cfg_wdata;
        REG_ZERO_LOW:      cfg_nxt.zero_low      = cfg_wdata;
        REG_ZERO_HIGH:     cfg_nxt.zero_high     = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // pipeline flow control
  assign out_adv   = !out_valid_r || out_ch.ready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign snap_load = in_acc && in_ch.window_end;

  always_comb begin
    lane_ctrl.take = in_acc;
    lane_ctrl.last = in_ch.window_end;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (snap_load) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_adv) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_mode    <= RST_CHECK_MODE;
      cfg_r.noise_limit   <= RST_NOISE_LIMIT;
      cfg_r.cal_main_low  <= RST_CAL_MAIN_LOW;
      cfg_r.cal_main_high <= RST_CAL_MAIN_HIGH;
      cfg_r.cal_aux_low   <= RST_CAL_AUX_LOW;
      cfg_r.cal_aux_high  <= RST_CAL_AUX_HIGH;
      cfg_r.zero_low      <= RST_ZERO_LOW;
      cfg_r.zero_high     <= RST_ZERO_HIGH;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sensor lanes
  dswhc_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MEAN_SHIFT  (MEAN_SHIFT),
    .ACC_W       (ACC_W)
  ) u_lane_main (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (lane_ctrl),
    .sample     (in_ch.main_sample),
    .smp_valid  (in_ch.main_valid),
    .snap_max_r (main_max),
    .snap_min_r (main_min),
    .snap_acc_r (main_acc),
    .snap_err_r (main_err)
  );

  dswhc_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MEAN_SHIFT  (MEAN_SHIFT),
    .ACC_W       (ACC_W)
  ) u_lane_aux (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (lane_ctrl),
    .sample     (in_ch.aux_sample),
    .smp_valid  (in_ch.aux_valid),
    .snap_max_r (aux_max),
    .snap_min_r (aux_min),
    .snap_acc_r (aux_acc),
    .snap_err_r (aux_err)
  );

  // verdict merge
  dswhc_merge #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MEAN_SHIFT  (MEAN_SHIFT),
    .ACC_W       (ACC_W)
  ) u_merge (
    .clk         (clk),
    .load        (s1_adv),
    .cfg         (cfg_r),
    .main_max    (main_max),
    .main_min    (main_min),
    .main_acc    (main_acc),
    .main_err    (main_err),
    .aux_max     (aux_max),
    .aux_min     (aux_min),
    .aux_acc     (aux_acc),
    .aux_err     (aux_err),
    .verdict_r   (verdict),
    .main_mean_r (main_mean),
    .aux_mean_r  (aux_mean)
  );

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pass          = verdict.pass;
  assign out_ch.capture_error = verdict.capture_error;
  assign out_ch.noise_fail    = verdict.noise_fail;
  assign out_ch.range_fail    = verdict.range_fail;
  assign out_ch.main_mean     = main_mean;
  assign out_ch.aux_mean      = aux_mean;

  // pending snapshot is never overwritten while the output is blocked
  `DSWHC_ASSERT_SAME(a_no_snap_overrun, s1_valid_r && !out_adv, !in_ch.ready)
  // a window end transaction always leaves a snapshot pending
  `DSWHC_ASSERT_NEXT(a_snap_pending, snap_load, s1_valid_r)
  // a moved snapshot always shows up as a result
  `DSWHC_ASSERT_NEXT(a_snap_to_out, s1_adv, out_valid_r)
  // pass is exactly the absence of every failure flag
  `DSWHC_ASSERT_SAME(a_pass_flags, out_valid_r,
    verdict.pass == !(verdict.capture_error || verdict.noise_fail || verdict.range_fail))

endmodule
